// ----- rtl/uecho_pkg.sv -----
`default_nettype none

package uecho_pkg;

    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 16;
    localparam int INDEX_W = 4;
    localparam int BIT_IDX_W = 4;

    typedef logic [INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_BIT_PERIOD = cfg_index_t'(0);
    localparam cfg_index_t CFG_HALF_BIT   = cfg_index_t'(1);

    localparam logic [TICK_W-1:0] BIT_PERIOD_RESET = 16'd833;
    localparam logic [TICK_W-1:0] HALF_BIT_RESET   = 16'd416;

    typedef struct packed {
        logic [TICK_W-1:0] bit_period_ticks;
        logic [TICK_W-1:0] half_bit_ticks;
    } cfg_t;

    typedef struct packed {
        logic              tx_level;
        logic              byte_valid;
        logic [BYTE_W-1:0] received_byte;
        logic              busy_res;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/uecho_if.sv -----
`default_nettype none

interface uecho_sample_if;
    logic valid;
    logic ready;
    logic rx_level;

    modport source (output valid, output rx_level, input ready);
    modport sink (input valid, input rx_level, output ready);
endinterface

interface uecho_result_if;
    logic                           valid;
    logic                           ready;
    logic                           tx_level;
    logic                           byte_valid;
    logic [uecho_pkg::BYTE_W-1:0]   received_byte;
    logic                           busy_res;

    modport source (output valid, output tx_level, output byte_valid,
                    output received_byte, output busy_res, input ready);
    modport sink (input valid, input tx_level, input byte_valid,
                  input received_byte, input busy_res, output ready);
endinterface

interface uecho_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [uecho_pkg::INDEX_W-1:0] index;
    logic [uecho_pkg::TICK_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/uecho_cfg_regs.sv -----
`default_nettype none

module uecho_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [uecho_pkg::INDEX_W-1:0] wr_index,
    input  wire logic [uecho_pkg::TICK_W-1:0]  wr_data,
    output uecho_pkg::cfg_t                    cfg
);

    uecho_pkg::cfg_t cfg_reg;
    uecho_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                uecho_pkg::CFG_BIT_PERIOD: cfg_next.bit_period_ticks = wr_data;
                uecho_pkg::CFG_HALF_BIT:   cfg_next.half_bit_ticks   = wr_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period_ticks <= uecho_pkg::BIT_PERIOD_RESET;
            cfg_reg.half_bit_ticks   <= uecho_pkg::HALF_BIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/uecho_core.sv -----
`default_nettype none

module uecho_core #(
    parameter int DATA_BITS = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire logic            rx_level,
    input  wire uecho_pkg::cfg_t cfg,
    output uecho_pkg::res_t      res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CHECK,
        PH_RXDATA,
        PH_RXSTOP,
        PH_TXSTART,
        PH_TXDATA,
        PH_TXSTOP
    } phase_t;

    localparam logic [uecho_pkg::BIT_IDX_W-1:0] LAST_BIT =
        uecho_pkg::BIT_IDX_W'(DATA_BITS);
    localparam logic [uecho_pkg::BIT_IDX_W-1:0] BYTE_BITS =
        uecho_pkg::BIT_IDX_W'(uecho_pkg::BYTE_W);

    phase_t                              phase_reg, phase_next;
    logic [uecho_pkg::TICK_W-1:0]        tick_reg, tick_next;
    logic [uecho_pkg::BIT_IDX_W-1:0]     idx_reg, idx_next;
    logic [uecho_pkg::BYTE_W-1:0]        shift_reg, shift_next;
    logic                                line_reg, line_next;

    logic [uecho_pkg::TICK_W:0]          tick_inc;
    logic [uecho_pkg::TICK_W-1:0]        period;
    logic                                done;
    logic [uecho_pkg::BIT_IDX_W-1:0]     idx_inc;
    logic                                valid;

    assign tick_inc = {1'b0, tick_reg} + (uecho_pkg::TICK_W+1)'(1);
    assign period   = (phase_reg == PH_CHECK) ? cfg.half_bit_ticks : cfg.bit_period_ticks;
    assign done     = (tick_inc >= {1'b0, period});
    assign idx_inc  = idx_reg + uecho_pkg::BIT_IDX_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        line_next  = line_reg;
        valid      = 1'b0;

        if (phase_reg != PH_IDLE)
        begin
            tick_next = done ? '0 : tick_inc[uecho_pkg::TICK_W-1:0];
        end

        unique case (phase_reg)
            PH_CHECK:
            begin
                if (done)
                begin
                    if (rx_level)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_RXDATA;
                        idx_next   = '0;
                        shift_next = '0;
                    end
                end
            end
            PH_RXDATA:
            begin
                if (done)
                begin
                    if (rx_level && (idx_reg < BYTE_BITS))
                    begin
                        shift_next = shift_reg | (uecho_pkg::BYTE_W'(1) << idx_reg[2:0]);
                    end
                    idx_next = idx_inc;
                    if (idx_inc >= LAST_BIT)
                    begin
                        phase_next = PH_RXSTOP;
                    end
                end
            end
            PH_RXSTOP:
            begin
                if (done)
                begin
                    valid      = 1'b1;
                    phase_next = PH_TXSTART;
                    line_next  = 1'b0;
                end
            end
            PH_TXSTART:
            begin
                if (done)
                begin
                    phase_next = PH_TXDATA;
                    idx_next   = '0;
                    line_next  = shift_reg[0];
                end
            end
            PH_TXDATA:
            begin
                if (done)
                begin
                    idx_next = idx_inc;
                    if (idx_inc >= LAST_BIT)
                    begin
                        phase_next = PH_TXSTOP;
                        line_next  = 1'b1;
                    end
                    else
                    begin
                        line_next = (idx_inc < BYTE_BITS) ? shift_reg[idx_inc[2:0]] : 1'b0;
                    end
                end
            end
            PH_TXSTOP:
            begin
                if (done)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                line_next  = 1'b1;
                if (!rx_level)
                begin
                    phase_next = PH_CHECK;
                    tick_next  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            idx_reg   <= '0;
            shift_reg <= '0;
            line_reg  <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            line_reg  <= line_next;
        end
    end

    assign res.tx_level      = line_next;
    assign res.byte_valid    = valid;
    assign res.received_byte = shift_next;
    assign res.busy_res      = (phase_next != PH_IDLE);

endmodule

`default_nettype wire

// ----- rtl/uart_8n1_echo.sv -----
// 8N1 serial echo, one sample transfer per oversampling clock tick.
// sample: one transfer per tick carrying the sampled receive line level.
// result: one transfer per sample giving the transmit line level, a strobe
//   with the received byte when a reception's stop-bit time ends, and busy.
// cfg: writes bit_period_ticks (index 0) and half_bit_ticks (index 1);
//   other indexes are dropped; always ready; write only while idle.
// a sample is held in the input register, then the state update and
//   result are computed together and loaded into the result register,
//   from which the result is offered
// throughput is one sample per cycle while result is not stalled
// when result is stalled, the result register holds and one more sample is
//   held in the input register; sample.ready then drops until result moves
// reset clears state to idle with the transmit line high and restores the
//   register defaults of 833 and 416 ticks
`default_nettype none

module uart_8n1_echo #(
    parameter int DATA_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    uecho_sample_if.sink     sample,
    uecho_result_if.source   result,
    uecho_cfg_if.sink        cfg
);

    uecho_pkg::cfg_t cfg_val;
    uecho_pkg::res_t step_res;

    logic            in_full_reg;
    logic            rx_reg;
    logic            out_valid_reg;
    uecho_pkg::res_t out_reg;

    logic            advance;
    logic            step;
    logic            in_fire;

    assign advance      = !out_valid_reg || result.ready;
    assign step         = in_full_reg && advance;
    assign sample.ready = !in_full_reg || advance;
    assign in_fire      = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    uecho_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    uecho_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step),
        .rx_level (rx_reg),
        .cfg      (cfg_val),
        .res      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_full_reg <= 1'b1;
            end
            else if (step)
            begin
                in_full_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rx_reg <= sample.rx_level;
        end
        if (step)
        begin
            out_reg <= step_res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.tx_level      = out_reg.tx_level;
    assign result.byte_valid    = out_reg.byte_valid;
    assign result.received_byte = out_reg.received_byte;
    assign result.busy_res      = out_reg.busy_res;

    // a completed byte always moves on to the echo
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.byte_valid |-> out_reg.busy_res)
    else $error("byte strobe while idle");

    // idle line stays high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.busy_res |-> out_reg.tx_level)
    else $error("transmit line low while idle");

    // held sample is not lost while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !advance |=> in_full_reg && $stable(rx_reg))
    else $error("held sample dropped during stall");

endmodule

`default_nettype wire
